@@ hdl/tce_pkg.sv @@
// shared constants, types and helpers for the text console character engine
`timescale 1ns / 1ps

package tce_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int CELLS    = COLUMNS * ROWS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int CELL_W   = 16;
   localparam int TAB_STEP = 8;

   localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  TAB_MASK = COL_W'(TAB_STEP - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] SCROLL_N = ADDR_W'((ROWS - 1) * COLUMNS);

   localparam logic [7:0] BLANK_CHAR  = 8'd32;
   localparam logic [7:0] RESET_COLOR = 8'd7;

   localparam logic [7:0] CHAR_BS  = 8'd8;
   localparam logic [7:0] CHAR_TAB = 8'd9;
   localparam logic [7:0] CHAR_NL  = 8'd10;
   localparam logic [7:0] CHAR_CR  = 8'd13;

   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_MOVE  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r);
      cell_addr = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
   endfunction

endpackage

@@ hdl/tce_screen_ram.sv @@
// screen store: one write port, one registered read port
`timescale 1ns / 1ps

module tce_screen_ram (
   input  logic                                clock,
   input  tce_pkg::mem_req_type                mem_req,
   output logic [tce_pkg::CELL_W-1:0]          rd_data
);

   logic [tce_pkg::CELL_W-1:0] mem [tce_pkg::CELLS];
   logic [tce_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tce_ctrl.sv @@
// sequencer: cursor, put/tab/backspace handling, scroll, clear and result register
`timescale 1ns / 1ps

module tce_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_kind,
   input  logic [7:0]                         req_char_code,
   input  logic [7:0]                         req_col,
   input  logic [7:0]                         req_row,
   input  logic [7:0]                         text_color,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tce_pkg::COL_W-1:0]          rsp_cursor_col,
   output logic [tce_pkg::ROW_W-1:0]          rsp_cursor_row,
   output logic [7:0]                         rsp_cell_char,
   output logic [7:0]                         rsp_cell_color,
   output tce_pkg::mem_req_type               mem_req,
   input  logic [tce_pkg::CELL_W-1:0]         rd_data
);

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_TAB    = 7'b0000100,
      S_SCROLL = 7'b0001000,
      S_BLANK  = 7'b0010000,
      S_CLEAR  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [tce_pkg::ADDR_W-1:0]      cnt_ff, cnt_in;
   logic [tce_pkg::COL_W-1:0]       col_ff, col_in;
   logic [tce_pkg::ROW_W-1:0]       row_ff, row_in;
   logic                            cell_sel_ff, cell_sel_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tce_pkg::COL_W-1:0]       rsp_col_ff, rsp_col_in;
   logic [tce_pkg::ROW_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [7:0]                      rsp_char_ff, rsp_char_in;
   logic [7:0]                      rsp_color_ff, rsp_color_in;

   logic [tce_pkg::COL_W-1:0]       col_clamp;
   logic [tce_pkg::ROW_W-1:0]       row_clamp;
   logic [tce_pkg::COL_W-1:0]       col_next;
   logic [tce_pkg::CELL_W-1:0]      blank_cell;

   assign col_clamp = (req_col >= 8'(tce_pkg::COLUMNS)) ? tce_pkg::LAST_COL
                                                       : req_col[tce_pkg::COL_W-1:0];
   assign row_clamp = (req_row >= 8'(tce_pkg::ROWS)) ? tce_pkg::LAST_ROW
                                                    : req_row[tce_pkg::ROW_W-1:0];
   assign col_next   = col_ff + 1'b1;
   assign blank_cell = {text_color, tce_pkg::BLANK_CHAR};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cell_sel_in  = cell_sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_color_in = rsp_color_ff;
      req_ready    = (state_ff == S_IDLE);

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = cnt_ff;
      mem_req.wr_data = blank_cell;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = cnt_ff;

      case (state_ff)
         S_INIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = {tce_pkg::RESET_COLOR, tce_pkg::BLANK_CHAR};
            if (cnt_ff == tce_pkg::LAST_CELL) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cell_sel_in = 1'b0;
               state_in    = S_FINISH;
               case (req_kind)
                  tce_pkg::KIND_MOVE: begin
                     col_in = col_clamp;
                     row_in = row_clamp;
                  end
                  tce_pkg::KIND_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  tce_pkg::KIND_READ: begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = tce_pkg::cell_addr(col_clamp, row_clamp);
                     cell_sel_in     = 1'b1;
                  end
                  default: begin
                     case (req_char_code)
                        tce_pkg::CHAR_NL: begin
                           col_in = '0;
                           if (row_ff == tce_pkg::LAST_ROW) begin
                              cnt_in   = '0;
                              state_in = S_SCROLL;
                           end else begin
                              row_in = row_ff + 1'b1;
                           end
                        end
                        tce_pkg::CHAR_CR: begin
                           col_in = '0;
                        end
                        tce_pkg::CHAR_TAB: begin
                           state_in = S_TAB;
                        end
                        tce_pkg::CHAR_BS: begin
                           if (col_ff != '0) begin
                              col_in          = col_ff - 1'b1;
                              mem_req.wr_en   = 1'b1;
                              mem_req.wr_addr = tce_pkg::cell_addr(col_ff - 1'b1, row_ff);
                           end else if (row_ff != '0) begin
                              col_in          = tce_pkg::LAST_COL;
                              row_in          = row_ff - 1'b1;
                              mem_req.wr_en   = 1'b1;
                              mem_req.wr_addr = tce_pkg::cell_addr(tce_pkg::LAST_COL,
                                                                   row_ff - 1'b1);
                           end
                        end
                        default: begin
                           mem_req.wr_en   = 1'b1;
                           mem_req.wr_addr = tce_pkg::cell_addr(col_ff, row_ff);
                           mem_req.wr_data = {text_color, req_char_code};
                           if (col_ff == tce_pkg::LAST_COL) begin
                              col_in = '0;
                              if (row_ff == tce_pkg::LAST_ROW) begin
                                 cnt_in   = '0;
                                 state_in = S_SCROLL;
                              end else begin
                                 row_in = row_ff + 1'b1;
                              end
                           end else begin
                              col_in = col_next;
                           end
                        end
                     endcase
                  end
               endcase
            end
         end
         S_TAB: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tce_pkg::cell_addr(col_ff, row_ff);
            if (col_ff == tce_pkg::LAST_COL) begin
               col_in = '0;
               if (row_ff == tce_pkg::LAST_ROW) begin
                  cnt_in   = '0;
                  state_in = S_SCROLL;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_FINISH;
               end
            end else begin
               col_in = col_next;
               if ((col_next & tce_pkg::TAB_MASK) == '0) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCROLL: begin
            // read one row ahead, write the word read last cycle one row up
            if (cnt_ff != tce_pkg::SCROLL_N) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cnt_ff + tce_pkg::ADDR_W'(tce_pkg::COLUMNS);
            end
            if (cnt_ff != '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cnt_ff - 1'b1;
               mem_req.wr_data = rd_data;
            end
            if (cnt_ff == tce_pkg::SCROLL_N) begin
               cnt_in   = '0;
               state_in = S_BLANK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_BLANK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tce_pkg::SCROLL_N + cnt_ff;
            if (cnt_ff == tce_pkg::ADDR_W'(tce_pkg::LAST_COL)) begin
               cnt_in   = '0;
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CLEAR: begin
            mem_req.wr_en = 1'b1;
            if (cnt_ff == tce_pkg::LAST_CELL) begin
               cnt_in   = '0;
               col_in   = '0;
               row_in   = '0;
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_ff;
               rsp_row_in   = row_ff;
               rsp_char_in  = cell_sel_ff ? rd_data[7:0] : 8'd0;
               rsp_color_in = cell_sel_ff ? rd_data[15:8] : 8'd0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cell_sel_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cell_sel_ff  <= cell_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_color = rsp_color_ff;

endmodule

@@ hdl/text_console_character_engine_unit.sv @@
// top level: color register, sequencer and screen store
// result: registered from the finish state once the result port is free; a tab first blanks cells
//   up to the next tab stop, a scroll moves rows up and blanks the bottom line, a clear blanks every cell
// flow: one item in flight, no new item is taken until the last result is registered; a waiting result holds input
// reset: synchronous; a clearing pass fills the store with spaces in color 7
//   before the first item is taken; color register goes to 7
`timescale 1ns / 1ps

module text_console_character_engine_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [7:0]                 csr_text_color,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_kind,
   input  logic [7:0]                 req_char_code,
   input  logic [7:0]                 req_col,
   input  logic [7:0]                 req_row,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tce_pkg::COL_W-1:0]  rsp_cursor_col,
   output logic [tce_pkg::ROW_W-1:0]  rsp_cursor_row,
   output logic [7:0]                 rsp_cell_char,
   output logic [7:0]                 rsp_cell_color
);

   logic [7:0]                   text_color_ff, text_color_in;
   tce_pkg::mem_req_type         mem_req;
   logic [tce_pkg::CELL_W-1:0]   rd_data;

   assign csr_ready     = 1'b1;
   assign text_color_in = (csr_valid && csr_ready) ? csr_text_color : text_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= tce_pkg::RESET_COLOR;
      end else begin
         text_color_ff <= text_color_in;
      end
   end

   tce_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_col        (req_col),
      .req_row        (req_row),
      .text_color     (text_color_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_color (rsp_cell_color),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   tce_screen_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // clearing pass blocks items right after reset
   assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("item port ready during reset clearing pass");

   // the sequencer never takes two items back to back
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer took two items back to back");

   // reported cursor always lies on the screen
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> (rsp_cursor_col <= tce_pkg::LAST_COL &&
                                   rsp_cursor_row <= tce_pkg::LAST_ROW))
      else $error("cursor outside the screen");

   // no store write while the sequencer waits for an item
   assert property (@(posedge clock) disable iff (reset)
                    (req_ready && !req_valid) |-> !mem_req.wr_en)
      else $error("screen store written while idle");

endmodule

@@ tb/sv/testbench.sv @@
// testbench for the text console character engine, checked beat by beat against a predictor
`timescale 1ns / 1ps

module testbench;
   import tce_pkg::*;

   localparam int N_DIRECTED      = 25;
   localparam int N_PHASES        = 6;
   localparam int ITEMS_PER_PHASE = 330;
   localparam int HEAVY_BUDGET    = 150;
   localparam int HOLD_AT_BEAT    = 600;
   localparam int HOLD_CYCLES     = 400;
   localparam int TAIL_CYCLES     = 50;
   localparam int MAX_PRINTS      = 20;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic [7:0] col;
      logic [7:0] row;
   } console_item_type;

   typedef struct packed {
      logic [COL_W-1:0] cursor_col;
      logic [ROW_W-1:0] cursor_row;
      logic [7:0]       cell_char;
      logic [7:0]       cell_color;
   } console_view_type;

   typedef struct packed {
      console_item_type item;
      logic             typed;
      console_view_type want;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] color;
      logic [7:0] glyph;
   } cell_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_text_color = 8'd0;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_kind = KIND_PUT;
   logic [7:0] req_char_code = 8'd0;
   logic [7:0] req_col = 8'd0;
   logic [7:0] req_row = 8'd0;

   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [COL_W-1:0] rsp_cursor_col;
   logic [ROW_W-1:0] rsp_cursor_row;
   logic [7:0]       rsp_cell_char;
   logic [7:0]       rsp_cell_color;

   // predictor state
   cell_type   screen_img [CELLS];
   int         cur_col;
   int         cur_row;
   logic [7:0] text_color;

   console_view_type due_views [$];
   int err_count     = 0;
   int views_checked = 0;
   int items_sent    = 0;
   int heavy_count   = 0;
   int colors_used   = 0;
   int burst_left    = 0;

   // cursor fields of untyped rows are left at zero and never used
   directed_row_type directed [N_DIRECTED] = '{
      {KIND_READ,  8'd0,     8'd0,   8'd0,   1'b1, 7'd0,  5'd0,  BLANK_CHAR, RESET_COLOR},
      {KIND_READ,  8'd0,     8'd255, 8'd255, 1'b1, 7'd0,  5'd0,  BLANK_CHAR, RESET_COLOR},
      {KIND_PUT,   CHAR_BS,  8'd0,   8'd0,   1'b1, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_PUT,   8'd65,    8'd255, 8'd255, 1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_PUT,   8'd255,   8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_PUT,   8'd0,     8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_PUT,   CHAR_TAB, 8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_MOVE,  8'd0,     8'd255, 8'd0,   1'b1, 7'd79, 5'd0,  8'd0, 8'd0},
      {KIND_PUT,   8'd90,    8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_READ,  8'd0,     8'd79,  8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_PUT,   CHAR_BS,  8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_MOVE,  8'd0,     8'd77,  8'd3,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_PUT,   CHAR_TAB, 8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_PUT,   8'd120,   8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_PUT,   CHAR_CR,  8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_MOVE,  8'd0,     8'd5,   8'd255, 1'b1, 7'd5,  5'd24, 8'd0, 8'd0},
      {KIND_PUT,   CHAR_NL,  8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_READ,  8'd0,     8'd0,   8'd23,  1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_MOVE,  8'd0,     8'd79,  8'd24,  1'b1, 7'd79, 5'd24, 8'd0, 8'd0},
      {KIND_PUT,   8'd113,   8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_MOVE,  8'd0,     8'd74,  8'd24,  1'b1, 7'd74, 5'd24, 8'd0, 8'd0},
      {KIND_PUT,   CHAR_TAB, 8'd0,   8'd0,   1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_READ,  8'd0,     8'd74,  8'd23,  1'b0, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_CLEAR, 8'd255,   8'd255, 8'd255, 1'b1, 7'd0,  5'd0,  8'd0, 8'd0},
      {KIND_READ,  8'd0,     8'd40,  8'd12,  1'b1, 7'd0,  5'd0,  BLANK_CHAR, RESET_COLOR}
   };

   text_console_character_engine_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_text_color (csr_text_color),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_color (rsp_cell_color)
   );

   always #4 clock = ~clock;

   task automatic blank_screen();
      int i;
      for (i = 0; i < CELLS; i++) screen_img[i] = {text_color, BLANK_CHAR};
   endtask

   task automatic paint_cell(input int c, input int r, input logic [7:0] ch);
      screen_img[r * COLUMNS + c] = {text_color, ch};
   endtask

   task automatic console_apply(input console_item_type it, output console_view_type v,
                                output bit heavy);
      int x, y, c, r, stop, i;
      c = cur_col;
      r = cur_row;
      x = (it.col >= COLUMNS) ? COLUMNS - 1 : int'(it.col);
      y = (it.row >= ROWS) ? ROWS - 1 : int'(it.row);
      v = '0;
      heavy = 1'b0;
      case (it.kind)
         KIND_PUT: begin
            case (it.char_code)
               CHAR_NL: begin
                  c = 0;
                  r++;
               end
               CHAR_CR: c = 0;
               CHAR_TAB: begin
                  stop = (c + TAB_STEP) & ~(TAB_STEP - 1);
                  while (c < stop && c < COLUMNS) begin
                     paint_cell(c, r, BLANK_CHAR);
                     c++;
                  end
               end
               CHAR_BS: begin
                  if (c > 0) begin
                     c--;
                     paint_cell(c, r, BLANK_CHAR);
                  end else if (r > 0) begin
                     r--;
                     c = COLUMNS - 1;
                     paint_cell(c, r, BLANK_CHAR);
                  end
               end
               default: begin
                  paint_cell(c, r, it.char_code);
                  c++;
               end
            endcase
            if (c >= COLUMNS) begin
               c = 0;
               r++;
            end
            if (r >= ROWS) begin
               // scroll up one line, fresh bottom line in the current color
               for (i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
               for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                  screen_img[i] = {text_color, BLANK_CHAR};
               r = ROWS - 1;
               heavy = 1'b1;
            end
         end
         KIND_MOVE: begin
            c = x;
            r = y;
         end
         KIND_CLEAR: begin
            blank_screen();
            c = 0;
            r = 0;
            heavy = 1'b1;
         end
         default: begin
            v.cell_char  = screen_img[y * COLUMNS + x].glyph;
            v.cell_color = screen_img[y * COLUMNS + x].color;
         end
      endcase
      cur_col = c;
      cur_row = r;
      v.cursor_col = COL_W'(c);
      v.cursor_row = ROW_W'(r);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (err_count < MAX_PRINTS)
         $display("mismatch at beat %0d: %s got %0d want %0d", views_checked, what, got, want);
      err_count++;
   endtask

   task automatic check_view();
      console_view_type want;
      if (due_views.size() == 0) begin
         report_mismatch("result beat with nothing due", 1, 0);
         return;
      end
      want = due_views.pop_front();
      if (rsp_cursor_col !== want.cursor_col)
         report_mismatch("cursor_col", int'(rsp_cursor_col), int'(want.cursor_col));
      if (rsp_cursor_row !== want.cursor_row)
         report_mismatch("cursor_row", int'(rsp_cursor_row), int'(want.cursor_row));
      if (rsp_cell_char !== want.cell_char)
         report_mismatch("cell_char", int'(rsp_cell_char), int'(want.cell_char));
      if (rsp_cell_color !== want.cell_color)
         report_mismatch("cell_color", int'(rsp_cell_color), int'(want.cell_color));
      views_checked++;
   endtask

   function automatic logic [7:0] pick_coord(input int limit);
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return 8'($urandom_range(0, limit - 1));
   endfunction

   function automatic console_item_type pick_item();
      console_item_type it;
      int sel;
      it.kind      = KIND_PUT;
      it.char_code = 8'($urandom);
      it.col       = 8'($urandom);
      it.row       = 8'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         it.char_code = 8'($urandom_range(32, 126));
      end else if (sel < 50) begin
         it.char_code = 8'($urandom);
      end else if (sel < 58) begin
         case ($urandom_range(0, 3))
            0: it.char_code = CHAR_NL;
            1: it.char_code = CHAR_CR;
            2: it.char_code = CHAR_TAB;
            default: it.char_code = CHAR_BS;
         endcase
      end else if (sel < 72) begin
         it.kind = KIND_MOVE;
         it.col  = pick_coord(COLUMNS);
         it.row  = pick_coord(ROWS);
      end else if (sel < 99) begin
         it.kind = KIND_READ;
         it.col  = pick_coord(COLUMNS);
         it.row  = pick_coord(ROWS);
      end else begin
         it.kind = KIND_CLEAR;
      end
      // keep the number of full-screen walks bounded
      if (heavy_count >= HEAVY_BUDGET) begin
         if (it.kind == KIND_CLEAR) it.kind = KIND_READ;
         if (it.kind == KIND_PUT && cur_row == ROWS - 1) begin
            it.kind = KIND_MOVE;
            it.row  = 8'($urandom_range(0, ROWS - 2));
         end
      end
      return it;
   endfunction

   task automatic offer_item(input console_item_type it, input bit typed,
                             input console_view_type want);
      console_view_type pred;
      bit heavy;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_kind      <= it.kind;
      req_char_code <= it.char_code;
      req_col       <= it.col;
      req_row       <= it.row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      console_apply(it, pred, heavy);
      if (heavy) heavy_count++;
      due_views.push_back(typed ? want : pred);
      items_sent++;
      burst_left--;
   endtask

   task automatic drain_views();
      req_valid <= 1'b0;
      while (due_views.size() != 0) @(posedge clock);
   endtask

   task automatic write_color(input logic [7:0] shade);
      csr_valid      <= 1'b1;
      csr_text_color <= shade;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      text_color = shade;
      colors_used++;
   endtask

   initial begin : rsp_side
      int step;
      int mode;
      bit held;
      step = 0;
      mode = 0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_view();
         step++;
         if (step % 64 == 0) mode = $urandom_range(0, 2);
         if (!held && views_checked >= HOLD_AT_BEAT) begin
            // long stall so the block backs up onto its input
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (step % 4 == 0);
         endcase
      end
   end

   initial begin : stimulus
      int i, p, n;
      logic [7:0] shade;
      text_color = RESET_COLOR;
      blank_screen();
      cur_col = 0;
      cur_row = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++)
         offer_item(directed[i].item, directed[i].typed, directed[i].want);

      for (p = 0; p < N_PHASES; p++) begin
         drain_views();
         case (p)
            0: shade = 8'h00;
            1: shade = 8'hFF;
            default: shade = 8'($urandom);
         endcase
         write_color(shade);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 2 && n == ITEMS_PER_PHASE / 2) drain_views();
            offer_item(pick_item(), 1'b0, '0);
         end
      end
      drain_views();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d items (%0d scrolls or clears) under %0d color settings",
               items_sent, heavy_count, colors_used);
      $display("checked %0d result beats, %0d mismatches", views_checked, err_count);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("timeout with %0d results still due", due_views.size());
      $display("status: fail");
      $finish;
   end

endmodule
